// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset.
`define CHK_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication under a synchronous active-low reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ----- hw/rtl/f5p_pkg.sv -----
// Shared constants, types and decode helpers of the five-stage pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package f5p_pkg;
    localparam int MEM_WORDS = 1024;
    localparam int AW = $clog2(MEM_WORDS);

    localparam logic [9:0] OP_ADD  = 10'd0;
    localparam logic [9:0] OP_NAND = 10'd1;
    localparam logic [9:0] OP_LW   = 10'd2;
    localparam logic [9:0] OP_SW   = 10'd3;
    localparam logic [9:0] OP_BEQ  = 10'd4;
    localparam logic [9:0] OP_HALT = 10'd6;
    localparam logic [31:0] NOOP_WORD = 32'h01c0_0000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef struct packed {
        logic        squash;
        logic        stall;
        logic [31:0] mw_value;
        logic [9:0]  mw_addr;
        logic        mw_valid;
        logic [31:0] rw_value;
        logic [2:0]  rw_index;
        logic        rw_valid;
        logic [31:0] cycles;
        logic [9:0]  pc;
        logic        halted;
    } t_result;

    function automatic logic [9:0] op_of(input logic [31:0] w);
        return w[31:22];
    endfunction

    function automatic logic [2:0] ra_of(input logic [31:0] w);
        return w[21:19];
    endfunction

    function automatic logic [2:0] rb_of(input logic [31:0] w);
        return w[18:16];
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/five_stage_pipeline_forwarding.sv -----
// Top level: stream ports, instruction and data stores, core and output register.
// Uses f5p_pkg, f5p_ram and f5p_core.
`timescale 1ns / 1ps
`default_nettype none
// Cycle-level model of a five-stage pipelined CPU (add, nand, lw, sw, beq, halt,
// noop; eight 32-bit registers). Each input item is either a load, which writes a
// word into both the instruction and the data store, or a step, which advances
// the pipeline unless it has halted. Every item yields one result: halt flag, pc,
// cycle count and the register write, store write, load-use bubble and branch
// squash of that cycle. The stores are synchronous RAMs read ahead at the address
// the updated state selects, with write-through on a same-address write, so an
// item may follow in the next cycle. Results wait in an output register and appear
// the cycle after their item is taken; input is taken, one item per clock,
// whenever that register is empty or being emptied, and never during reset.
// Unwritten store words read as unknown.
module five_stage_pipeline_forwarding (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,  // load_addr[9:0], load_word[41:10], zero pad
    input  wire logic         s_axis_tuser,  // cmd
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [127:0] m_axis_tdata   // halted, pc_value, cycle_total,
                                             // reg_write_valid/index/value,
                                             // mem_write_valid/addr/value,
                                             // load_stall, branch_squash, zero pad
);
    localparam int AW = f5p_pkg::AW;

    logic take;
    logic [AW-1:0] imem_raddr, dmem_raddr, dmem_waddr;
    logic [31:0] imem_q, dmem_q, dmem_wdata;
    logic dmem_we, imem_we;
    f5p_pkg::t_result result;
    logic r_out_valid;
    f5p_pkg::t_result r_out;

    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign take = s_axis_tvalid && s_axis_tready;
    assign imem_we = take && (s_axis_tuser == f5p_pkg::CMD_LOAD);

    f5p_ram #(.WIDTH(32), .DEPTH(f5p_pkg::MEM_WORDS)) u_imem (
        .i_clk(i_clk), .i_we(imem_we), .i_waddr(AW'(s_axis_tdata[9:0])),
        .i_wdata(s_axis_tdata[41:10]), .i_raddr(imem_raddr), .o_rdata(imem_q)
    );
    f5p_ram #(.WIDTH(32), .DEPTH(f5p_pkg::MEM_WORDS)) u_dmem (
        .i_clk(i_clk), .i_we(dmem_we), .i_waddr(dmem_waddr),
        .i_wdata(dmem_wdata), .i_raddr(dmem_raddr), .o_rdata(dmem_q)
    );

    f5p_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_cmd(s_axis_tuser),
        .i_load_addr(s_axis_tdata[9:0]), .i_load_word(s_axis_tdata[41:10]),
        .i_imem_q(imem_q), .i_dmem_q(dmem_q),
        .o_imem_raddr(imem_raddr), .o_dmem_raddr(dmem_raddr),
        .o_dmem_we(dmem_we), .o_dmem_waddr(dmem_waddr), .o_dmem_wdata(dmem_wdata),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {4'd0, r_out};
endmodule
`default_nettype wire

// ----- hw/rtl/f5p_ram.sv -----
// Generic synchronous RAM: one write port, one registered read port.
// A read of the address being written returns the new data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module f5p_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/f5p_core.sv -----
// Pipeline latches, hazard detection, forwarding and the register file.
// Uses f5p_pkg and f5p_ram; the stores sit outside and are read ahead.
`timescale 1ns / 1ps
`default_nettype none
module f5p_core (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_take,
    input  wire logic                    i_cmd,
    input  wire logic [9:0]              i_load_addr,
    input  wire logic [31:0]             i_load_word,
    input  wire logic [31:0]             i_imem_q,
    input  wire logic [31:0]             i_dmem_q,
    output logic      [f5p_pkg::AW-1:0]  o_imem_raddr,
    output logic      [f5p_pkg::AW-1:0]  o_dmem_raddr,
    output logic                         o_dmem_we,
    output logic      [f5p_pkg::AW-1:0]  o_dmem_waddr,
    output logic      [31:0]             o_dmem_wdata,
    output f5p_pkg::t_result             o_result
);
    localparam int AW = f5p_pkg::AW;

    logic [AW-1:0] r_pc, r_fnpc, r_dnpc, r_et;
    logic [AW-1:0] n_pc, n_fnpc, n_dnpc, n_et;
    logic [31:0] r_fw, r_dw, r_ew, r_mw, r_rw;
    logic [31:0] n_fw, n_dw, n_ew, n_mw;
    logic [31:0] r_da, r_db, r_ealu, r_evb, r_md, r_rd, r_cyc;
    logic [31:0] n_da, n_db, n_ealu, n_evb, n_md;
    logic [15:0] r_doff, n_doff;
    logic [7:0]  r_rf_valid;
    logic        r_ok_a, r_ok_b;

    logic        halted_now, step, stall, squash;
    logic        wb_we, mw_v;
    logic [2:0]  wb_idx, ra_addr, rb_addr;
    logic [AW-1:0] mw_a;
    logic [31:0] rf_qa, rf_qb, rf_a, rf_b, fa, fb, off_ext;

    function automatic logic has_dest(input logic [31:0] w);
        return (f5p_pkg::op_of(w) == f5p_pkg::OP_ADD) ||
               (f5p_pkg::op_of(w) == f5p_pkg::OP_NAND) ||
               (f5p_pkg::op_of(w) == f5p_pkg::OP_LW);
    endfunction

    function automatic logic [2:0] dest_of(input logic [31:0] w);
        return (f5p_pkg::op_of(w) == f5p_pkg::OP_LW) ? w[18:16] : w[2:0];
    endfunction

    function automatic logic is_alu(input logic [31:0] w);
        return (f5p_pkg::op_of(w) == f5p_pkg::OP_ADD) ||
               (f5p_pkg::op_of(w) == f5p_pkg::OP_NAND);
    endfunction

    // youngest producer wins: EX/MEM, then MEM/WB, then WB/END
    function automatic logic [31:0] fwd(input logic [2:0] r, input logic [31:0] v,
                                        input logic [31:0] ew, input logic [31:0] ealu,
                                        input logic [31:0] mw, input logic [31:0] md,
                                        input logic [31:0] rw, input logic [31:0] rd);
        logic [31:0] o;
        o = v;
        if (has_dest(rw) && dest_of(rw) == r) o = rd;
        if (has_dest(mw) && dest_of(mw) == r) o = md;
        if (is_alu(ew) && ew[2:0] == r) o = ealu;
        return o;
    endfunction

    assign rf_a = r_ok_a ? rf_qa : 32'd0;
    assign rf_b = r_ok_b ? rf_qb : 32'd0;
    assign halted_now = (f5p_pkg::op_of(r_mw) == f5p_pkg::OP_HALT);
    assign step = i_take && (i_cmd == f5p_pkg::CMD_STEP) && !halted_now;
    assign off_ext = {{16{r_doff[15]}}, r_doff};
    assign fa = fwd(f5p_pkg::ra_of(r_dw), r_da, r_ew, r_ealu, r_mw, r_md, r_rw, r_rd);
    assign fb = fwd(f5p_pkg::rb_of(r_dw), r_db, r_ew, r_ealu, r_mw, r_md, r_rw, r_rd);

    always_comb begin
        n_pc = r_pc; n_fw = r_fw; n_fnpc = r_fnpc;
        n_dw = r_dw; n_dnpc = r_dnpc; n_da = r_da; n_db = r_db; n_doff = r_doff;
        n_ew = r_ew; n_et = r_et; n_ealu = r_ealu; n_evb = r_evb;
        n_mw = r_mw; n_md = r_md;
        stall = 1'b0; squash = 1'b0; mw_v = 1'b0; mw_a = '0;
        wb_we = 1'b0; wb_idx = '0;
        if (step) begin
            n_fw = i_imem_q;
            n_pc = r_pc + AW'(1);
            n_fnpc = n_pc;
            n_dw = r_fw; n_dnpc = r_fnpc;
            n_da = rf_a; n_db = rf_b; n_doff = r_fw[15:0];
            if (f5p_pkg::op_of(r_dw) == f5p_pkg::OP_LW &&
                (f5p_pkg::ra_of(r_fw) == f5p_pkg::rb_of(r_dw) ||
                 f5p_pkg::rb_of(r_fw) == f5p_pkg::rb_of(r_dw))) begin
                stall = 1'b1;
                n_dw = f5p_pkg::NOOP_WORD;
                n_fw = r_fw;
                n_fnpc = r_pc;
                n_pc = r_pc;
            end
            n_ew = r_dw; n_evb = r_db;
            n_et = r_dnpc + off_ext[AW-1:0];
            unique case (f5p_pkg::op_of(r_dw))
                f5p_pkg::OP_ADD:  n_ealu = fa + fb;
                f5p_pkg::OP_NAND: n_ealu = ~(fa & fb);
                f5p_pkg::OP_LW,
                f5p_pkg::OP_SW:   n_ealu = fa + off_ext;
                f5p_pkg::OP_BEQ:  n_ealu = {31'd0, fa == fb};
                default:          n_ealu = r_ealu;
            endcase
            n_mw = r_ew;
            unique case (f5p_pkg::op_of(r_ew))
                f5p_pkg::OP_ADD,
                f5p_pkg::OP_NAND: n_md = r_ealu;
                f5p_pkg::OP_LW:   n_md = i_dmem_q;
                f5p_pkg::OP_SW: begin
                    mw_v = 1'b1;
                    mw_a = r_ealu[AW-1:0];
                end
                f5p_pkg::OP_BEQ: begin
                    if (r_ealu == 32'd1) begin
                        squash = 1'b1;
                        stall = 1'b0;
                        n_pc = r_et;
                        n_fw = f5p_pkg::NOOP_WORD;
                        n_dw = f5p_pkg::NOOP_WORD;
                        n_ew = f5p_pkg::NOOP_WORD;
                    end
                end
                default: ;
            endcase
            wb_we = has_dest(r_mw);
            wb_idx = wb_we ? dest_of(r_mw) : 3'd0;
        end
    end

    // read ports follow the next state so data is ready for the next item
    assign o_imem_raddr = i_rst_n ? n_pc : '0;
    assign o_dmem_raddr = i_rst_n ? n_ealu[AW-1:0] : '0;
    assign ra_addr = i_rst_n ? f5p_pkg::ra_of(n_fw) : 3'd0;
    assign rb_addr = i_rst_n ? f5p_pkg::rb_of(n_fw) : 3'd0;
    assign o_dmem_we = (i_take && i_cmd == f5p_pkg::CMD_LOAD) || mw_v;
    assign o_dmem_waddr = mw_v ? mw_a : AW'(i_load_addr);
    assign o_dmem_wdata = mw_v ? r_evb : i_load_word;

    f5p_ram #(.WIDTH(32), .DEPTH(8)) u_rf_a (
        .i_clk(i_clk), .i_we(wb_we), .i_waddr(wb_idx), .i_wdata(r_md),
        .i_raddr(ra_addr), .o_rdata(rf_qa)
    );
    f5p_ram #(.WIDTH(32), .DEPTH(8)) u_rf_b (
        .i_clk(i_clk), .i_we(wb_we), .i_waddr(wb_idx), .i_wdata(r_md),
        .i_raddr(rb_addr), .o_rdata(rf_qb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0; r_fnpc <= '0; r_dnpc <= '0; r_et <= '0;
            r_fw <= f5p_pkg::NOOP_WORD; r_dw <= f5p_pkg::NOOP_WORD;
            r_ew <= f5p_pkg::NOOP_WORD; r_mw <= f5p_pkg::NOOP_WORD;
            r_rw <= f5p_pkg::NOOP_WORD;
            r_da <= '0; r_db <= '0; r_doff <= '0; r_ealu <= '0; r_evb <= '0;
            r_md <= '0; r_rd <= '0; r_cyc <= '0;
            r_rf_valid <= '0; r_ok_a <= 1'b0; r_ok_b <= 1'b0;
        end else begin
            r_ok_a <= r_rf_valid[ra_addr] || (wb_we && wb_idx == ra_addr);
            r_ok_b <= r_rf_valid[rb_addr] || (wb_we && wb_idx == rb_addr);
            if (wb_we) begin
                r_rf_valid[wb_idx] <= 1'b1;
            end
            if (step) begin
                r_pc <= n_pc; r_fw <= n_fw; r_fnpc <= n_fnpc;
                r_dw <= n_dw; r_dnpc <= n_dnpc; r_da <= n_da; r_db <= n_db;
                r_doff <= n_doff;
                r_ew <= n_ew; r_et <= n_et; r_ealu <= n_ealu; r_evb <= n_evb;
                r_rw <= r_mw; r_rd <= r_md;
                r_mw <= n_mw; r_md <= n_md;
                r_cyc <= r_cyc + 32'd1;
            end
        end
    end

    always_comb begin
        o_result.halted   = (f5p_pkg::op_of(n_mw) == f5p_pkg::OP_HALT);
        o_result.pc       = 10'(n_pc);
        o_result.cycles   = step ? r_cyc + 32'd1 : r_cyc;
        o_result.rw_valid = wb_we;
        o_result.rw_index = wb_idx;
        o_result.rw_value = wb_we ? r_md : 32'd0;
        o_result.mw_valid = mw_v;
        o_result.mw_addr  = 10'(mw_a);
        o_result.mw_value = mw_v ? r_evb : 32'd0;
        o_result.stall    = stall;
        o_result.squash   = squash;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/f5p_checker.sv -----
// Port-level checks of the pipeline block, bound to the top level.
// Uses assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module f5p_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata
);
    // hold a stalled result
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // squash overrides the bubble
    `CHK_NOW(a_no_stall_squash, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tdata[122] && m_axis_tdata[123]))
    // a squashing beq in MEM is never a store
    `CHK_NOW(a_squash_no_store, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[123], !m_axis_tdata[79])
    // no register write means zero index and value
    `CHK_NOW(a_rw_clean, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[43], m_axis_tdata[78:44] == 35'd0)
    // input ready is always high while no result waits
    `CHK_NOW(a_ready_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
endmodule

bind five_stage_pipeline_forwarding f5p_checker u_f5p_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
